// File: design/dtw_pkg.sv
// Shared types, constants and helper functions for the date-to-weekday block.
package dtw_pkg;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_YEAR      = 3'd1,
		ERR_MONTH     = 3'd2,
		ERR_NOT_LEAP  = 3'd3,
		ERR_DAY_RANGE = 3'd4,
		ERR_DAY_MONTH = 3'd5
	} err_code_t;

	localparam logic [11:0] YEAR_MIN   = 12'd1901;
	localparam logic [11:0] YEAR_MAX   = 12'd2092;
	localparam logic [11:0] YEAR_PIVOT = 12'd2000;
	localparam logic [11:0] CENT_19    = 12'd1900;
	localparam logic [6:0]  ROW_OFS_19 = 7'd3;
	localparam logic [6:0]  ROW_OFS_20 = 7'd19;
	localparam logic [4:0]  ROW_PIVOT  = 5'd19;
	localparam int          ROWS       = 28;
	localparam int          MONTHS     = 12;
	localparam logic [5:0]  DAY_MAX    = 6'd31;
	localparam logic [3:0]  FEBRUARY   = 4'd2;
	localparam logic [5:0]  LEAP_DAY   = 6'd29;

	typedef logic [0:MONTHS-1][2:0] rom_row_t;

	// Month lengths for the length check; February counts 29, unused codes 0.
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	// Year-row by month table: first weekday offset of each month.
	localparam rom_row_t ROW_ROM [ROWS] = '{
		'{3'd4,3'd0,3'd0,3'd3,3'd5,3'd1,3'd3,3'd6,3'd2,3'd4,3'd0,3'd2},
		'{3'd5,3'd1,3'd1,3'd4,3'd6,3'd2,3'd4,3'd0,3'd3,3'd5,3'd1,3'd3},
		'{3'd6,3'd2,3'd2,3'd5,3'd0,3'd3,3'd5,3'd1,3'd4,3'd6,3'd2,3'd4},
		'{3'd0,3'd3,3'd4,3'd0,3'd2,3'd5,3'd0,3'd3,3'd6,3'd1,3'd4,3'd6},
		'{3'd2,3'd5,3'd5,3'd1,3'd3,3'd6,3'd1,3'd4,3'd0,3'd2,3'd5,3'd0},
		'{3'd3,3'd6,3'd6,3'd2,3'd4,3'd0,3'd2,3'd5,3'd1,3'd3,3'd6,3'd1},
		'{3'd4,3'd0,3'd0,3'd3,3'd5,3'd1,3'd3,3'd6,3'd2,3'd4,3'd0,3'd2},
		'{3'd5,3'd1,3'd2,3'd5,3'd0,3'd3,3'd5,3'd1,3'd4,3'd6,3'd2,3'd4},
		'{3'd0,3'd3,3'd3,3'd6,3'd1,3'd4,3'd6,3'd2,3'd5,3'd0,3'd3,3'd5},
		'{3'd1,3'd4,3'd4,3'd0,3'd2,3'd5,3'd0,3'd3,3'd6,3'd1,3'd4,3'd6},
		'{3'd2,3'd5,3'd5,3'd1,3'd3,3'd6,3'd1,3'd4,3'd0,3'd2,3'd5,3'd0},
		'{3'd3,3'd6,3'd0,3'd3,3'd5,3'd1,3'd3,3'd6,3'd2,3'd4,3'd0,3'd2},
		'{3'd5,3'd1,3'd1,3'd4,3'd6,3'd2,3'd4,3'd0,3'd3,3'd5,3'd1,3'd3},
		'{3'd6,3'd2,3'd2,3'd5,3'd0,3'd3,3'd5,3'd1,3'd4,3'd6,3'd2,3'd4},
		'{3'd0,3'd3,3'd3,3'd6,3'd1,3'd4,3'd6,3'd2,3'd5,3'd0,3'd3,3'd5},
		'{3'd1,3'd4,3'd5,3'd1,3'd3,3'd6,3'd1,3'd4,3'd0,3'd2,3'd5,3'd0},
		'{3'd3,3'd6,3'd6,3'd2,3'd4,3'd0,3'd2,3'd5,3'd1,3'd3,3'd6,3'd1},
		'{3'd4,3'd0,3'd0,3'd3,3'd5,3'd1,3'd3,3'd6,3'd2,3'd4,3'd0,3'd2},
		'{3'd5,3'd1,3'd1,3'd4,3'd6,3'd2,3'd4,3'd0,3'd3,3'd5,3'd1,3'd3},
		'{3'd6,3'd2,3'd3,3'd6,3'd1,3'd4,3'd6,3'd2,3'd5,3'd0,3'd3,3'd5},
		'{3'd1,3'd4,3'd4,3'd0,3'd2,3'd5,3'd0,3'd3,3'd6,3'd1,3'd4,3'd6},
		'{3'd2,3'd5,3'd5,3'd1,3'd3,3'd6,3'd1,3'd4,3'd0,3'd2,3'd5,3'd0},
		'{3'd3,3'd6,3'd6,3'd2,3'd4,3'd0,3'd2,3'd5,3'd1,3'd3,3'd6,3'd1},
		'{3'd4,3'd0,3'd1,3'd4,3'd6,3'd2,3'd4,3'd0,3'd3,3'd5,3'd1,3'd3},
		'{3'd6,3'd2,3'd2,3'd5,3'd0,3'd3,3'd5,3'd1,3'd4,3'd6,3'd2,3'd4},
		'{3'd0,3'd3,3'd3,3'd6,3'd1,3'd4,3'd6,3'd2,3'd5,3'd0,3'd3,3'd5},
		'{3'd1,3'd4,3'd4,3'd0,3'd2,3'd5,3'd0,3'd3,3'd6,3'd1,3'd4,3'd6},
		'{3'd2,3'd5,3'd6,3'd2,3'd4,3'd0,3'd2,3'd5,3'd1,3'd3,3'd6,3'd1}
	};

	// Reduce a value below 112 modulo 28 by at most three subtractions.
	function automatic logic [4:0] mod28(input logic [6:0] x);
		logic [6:0] r;
		r = x;
		for (int i = 0; i < 3; i++) begin
			if (r >= 7'd28) begin
				r = r - 7'd28;
			end
		end
		return r[4:0];
	endfunction

	// Reduce a 6-bit value modulo 7 by folding octal digits (8 = 1 mod 7).
	function automatic logic [2:0] mod7(input logic [5:0] x);
		logic [3:0] a;
		logic [2:0] b;
		a = {1'b0, x[5:3]} + {1'b0, x[2:0]};
		b = a[2:0] + {2'b0, a[3]};
		return (b == 3'd7) ? 3'd0 : b;
	endfunction

endpackage

// File: design/dtw_ifs.sv
// Valid/ready channel interfaces for the date input and the weekday result.
interface dtw_date_if;
	logic        valid;
	logic        ready;
	logic [5:0]  day_of_month;
	logic [3:0]  month_number;
	logic [11:0] full_year;

	modport source (output valid, day_of_month, month_number, full_year, input ready);
	modport sink   (input valid, day_of_month, month_number, full_year, output ready);
endinterface

interface dtw_wday_if;
	logic       valid;
	logic       ready;
	logic [2:0] weekday;
	logic [2:0] error_code;

	modport source (output valid, weekday, error_code, input ready);
	modport sink   (input valid, weekday, error_code, output ready);
endinterface

// File: design/date_to_weekday.sv
// Date-to-weekday converter: validity checks and perpetual-calendar lookup.
// An accepted date beat passes the input register _s1 and then the result
// register _s2 before its result beat appears on wday_out.
// Throughput: one date per cycle; both stages advance together whenever the
// result register is empty or its beat is taken.
// Reset: arst_n clears both stage valid bits at once; payload is not reset.
module date_to_weekday
	import dtw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	dtw_date_if.sink   date_in,
	dtw_wday_if.source wday_out
);

	// Stage 1: registered date.
	logic        v_s1;
	logic [5:0]  day_s1;
	logic [3:0]  month_s1;
	logic [11:0] year_s1;

	// Stage 2: registered result.
	logic        v_s2;
	logic [2:0]  wday_s2;
	err_code_t   err_s2;

	logic adv_s2;   // result register may load
	logic adv_s1;   // input register may load

	// Result register frees up when empty or when its beat is taken;
	// the input register frees up when empty or when it moves forward.
	assign adv_s2 = !v_s2 || wday_out.ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign date_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= date_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && date_in.valid) begin
			day_s1   <= date_in.day_of_month;
			month_s1 <= date_in.month_number;
			year_s1  <= date_in.full_year;
		end
	end

	// ------------------------------------------------------------------
	// Checks, in priority order. Within 1901..2092 the only century year
	// is 2000, which is a leap year, so leap reduces to year mod 4 == 0.
	// ------------------------------------------------------------------
	logic      year_ok;
	logic      month_ok;
	logic      leap;
	logic      day_ok;
	logic [4:0] month_len;
	err_code_t err_d;

	assign year_ok   = (year_s1 >= YEAR_MIN) && (year_s1 <= YEAR_MAX);
	assign leap      = (year_s1[1:0] == 2'b00);
	assign day_ok    = (day_s1 != 6'd0) && (day_s1 <= DAY_MAX);
	assign month_len = MONTH_LEN[month_s1];

	always_comb begin
		month_ok = month_s1 inside {[4'd1:4'd12]};
		if (!year_ok) begin
			err_d = ERR_YEAR;
		end else if (!month_ok) begin
			err_d = ERR_MONTH;
		end else if (!leap && month_s1 == FEBRUARY && day_s1 == LEAP_DAY) begin
			err_d = ERR_NOT_LEAP;
		end else if (!day_ok) begin
			err_d = ERR_DAY_RANGE;
		end else if (day_s1 > {1'b0, month_len}) begin
			err_d = ERR_DAY_MONTH;
		end else begin
			err_d = ERR_NONE;
		end
	end

	// ------------------------------------------------------------------
	// Weekday: pick the year row from the two low decimal digits, look up
	// the month's offset, then add the day and reduce mod 7.
	// ------------------------------------------------------------------
	logic        before_pivot;
	logic [11:0] yy_full;
	logic [6:0]  row_sum;
	logic [4:0]  row;
	logic [3:0]  month_idx;
	rom_row_t    rom_row;
	logic [2:0]  rom_val;
	logic [5:0]  day_sum;
	logic [2:0]  wday_d;

	assign before_pivot = (year_s1 < YEAR_PIVOT);
	assign yy_full      = year_s1 - (before_pivot ? CENT_19 : YEAR_PIVOT);
	assign row_sum      = yy_full[6:0] + (before_pivot ? ROW_OFS_19 : ROW_OFS_20);
	assign row          = (year_s1 == YEAR_PIVOT) ? ROW_PIVOT : mod28(row_sum);
	assign month_idx    = month_s1 - 4'd1;
	assign rom_row      = ROW_ROM[row];
	assign rom_val      = rom_row[month_idx];
	assign day_sum      = {3'b000, rom_val} + day_s1 - 6'd1;
	// Hold weekday at zero on any error.
	assign wday_d       = (err_d == ERR_NONE) ? mod7(day_sum) : 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			wday_s2 <= wday_d;
			err_s2  <= err_d;
		end
	end

	assign wday_out.valid      = v_s2;
	assign wday_out.weekday    = wday_s2;
	assign wday_out.error_code = err_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_err_zero_wday: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && err_s2 != ERR_NONE) |-> (wday_s2 == 3'd0))
		else $error("weekday nonzero with error set");

	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (wday_s2 != 3'd7))
		else $error("weekday out of range");

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(date_in.valid && date_in.ready) |=> v_s1)
		else $error("accepted date beat lost before stage 1");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv_s1) |=> v_s2)
		else $error("stage 1 date lost before result register");

endmodule

// File: tb/sv/dtw_tb_pkg.sv
`timescale 1ns / 100ps
// Weekday predictor and result scoreboard for the date-to-weekday testbench.
package dtw_tb_pkg;
	import dtw_pkg::*;

	localparam int FIRST_YEAR = 1901;
	localparam int LAST_YEAR  = 2092;
	localparam int Y2K        = 2000;
	localparam int Y2K_ROW    = 19;
	localparam int FEB        = 2;

	// Longest day for the length check; February is allowed 29 here.
	localparam int MONTH_DAYS [16] = '{
		0, 31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0
	};

	// Weekday of the 1st by year row, one nibble per month, January leftmost.
	localparam logic [47:0] FIRST_WDAY [28] = '{
		48'h400351362402, 48'h511462403513, 48'h622503514624, 48'h034025036146,
		48'h255136140250, 48'h366240251361, 48'h400351362402, 48'h512503514624,
		48'h033614625035, 48'h144025036146, 48'h255136140250, 48'h360351362402,
		48'h511462403513, 48'h622503514624, 48'h033614625035, 48'h145136140250,
		48'h366240251361, 48'h400351362402, 48'h511462403513, 48'h623614625035,
		48'h144025036146, 48'h255136140250, 48'h366240251361, 48'h401462403513,
		48'h622503514624, 48'h033614625035, 48'h144025036146, 48'h256240251361
	};

	typedef struct packed {
		logic [2:0] weekday;
		err_code_t  error_code;
	} wday_beat_t;

	class weekday_scoreboard;
		wday_beat_t  wday_expected [$];
		int unsigned failures;

		function new();
			failures = 0;
		endfunction

		static function wday_beat_t predict(logic [5:0] day, logic [3:0] month,
			logic [11:0] year);
			wday_beat_t r;
			int         yr;
			int         mo;
			int         dy;
			int         row;
			int         first;
			bit         leap;
			yr = year;
			mo = month;
			dy = day;
			leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
			r.weekday = 3'd0;
			r.error_code = ERR_NONE;
			if (yr < FIRST_YEAR || yr > LAST_YEAR) begin
				r.error_code = ERR_YEAR;
			end else if (mo < 1 || mo > 12) begin
				r.error_code = ERR_MONTH;
			end else if (!leap && mo == FEB && dy == 29) begin
				r.error_code = ERR_NOT_LEAP;
			end else if (dy < 1 || dy > 31) begin
				r.error_code = ERR_DAY_RANGE;
			end else if (dy > MONTH_DAYS[mo]) begin
				r.error_code = ERR_DAY_MONTH;
			end else begin
				if (yr == Y2K) begin
					row = Y2K_ROW;
				end else if (yr < Y2K) begin
					row = (yr % 100 + 3) % 28;
				end else begin
					row = (yr % 100 + 19) % 28;
				end
				first = int'((FIRST_WDAY[row] >> (4 * (12 - mo))) & 48'hF);
				r.weekday = 3'((first + dy - 1) % 7);
			end
			return r;
		endfunction

		function void note_date(logic [5:0] day, logic [3:0] month, logic [11:0] year);
			wday_expected.push_back(predict(day, month, year));
		endfunction

		function void check_result(logic [2:0] weekday, logic [2:0] error_code);
			wday_beat_t e;
			if (wday_expected.size() == 0) begin
				$error("result beat with no date pending: weekday %0d error_code %0d",
					weekday, error_code);
				failures++;
				return;
			end
			e = wday_expected.pop_front();
			if (error_code !== e.error_code) begin
				$error("error_code mismatch: expected %0d, actual %0d",
					e.error_code, error_code);
				failures++;
			end
			if (weekday !== e.weekday) begin
				$error("weekday mismatch: expected %0d, actual %0d", e.weekday, weekday);
				failures++;
			end
		endfunction

		function int unsigned outstanding();
			return wday_expected.size();
		endfunction
	endclass

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top-level testbench for date_to_weekday: directed and random dates, random stalls.
module tb;
	import dtw_pkg::*;
	import dtw_tb_pkg::*;

	typedef struct packed {
		logic [5:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} date_t;

	// Boundaries of every field, each error code, and the precedence between them.
	localparam date_t DIRECTED_DATES [25] = '{
		'{6'd1,  4'd1,  12'd1901},  // first supported day
		'{6'd31, 4'd12, 12'd2092},  // last supported day
		'{6'd1,  4'd1,  12'd2000},  // year 2000 takes its own row
		'{6'd29, 4'd2,  12'd2000},  // leap by the 400 rule
		'{6'd29, 4'd2,  12'd1904},
		'{6'd29, 4'd2,  12'd1999},  // leap day in a common year
		'{6'd29, 4'd2,  12'd2001},
		'{6'd30, 4'd2,  12'd2000},  // past February in a leap year
		'{6'd30, 4'd2,  12'd1999},  // past February, not the leap-day code
		'{6'd31, 4'd4,  12'd2024},  // past a 30-day month
		'{6'd31, 4'd11, 12'd1950},
		'{6'd0,  4'd5,  12'd1980},  // day zero
		'{6'd32, 4'd5,  12'd1980},  // day just past 31
		'{6'd63, 4'd15, 12'd4095},  // all ones: year error wins
		'{6'd0,  4'd0,  12'd0},     // all zeros
		'{6'd1,  4'd1,  12'd1900},  // just below the range
		'{6'd1,  4'd1,  12'd2093},  // just above the range
		'{6'd15, 4'd0,  12'd2050},  // month zero
		'{6'd15, 4'd13, 12'd2050},  // month just past December
		'{6'd63, 4'd15, 12'd2050},  // month error beats day error
		'{6'd29, 4'd2,  12'd2100},  // common century, but out of range first
		'{6'd0,  4'd2,  12'd1901},  // day zero in February of a common year
		'{6'd31, 4'd1,  12'd2099},
		'{6'd28, 4'd2,  12'd2091},
		'{6'd63, 4'd2,  12'd1903}   // wild day in February of a common year
	};

	localparam int RANDOM_DATES = 1150;

	logic clk;
	logic arst_n;
	bit   calm;   // suppress all stalls on both sides while set

	dtw_date_if date_ch ();
	dtw_wday_if wday_ch ();

	weekday_scoreboard sb = new();

	date_to_weekday u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.date_in  (date_ch),
		.wday_out (wday_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Offer one date; hold valid low for random cycles first, then wait for the beat.
	task automatic send_date(input date_t dt);
		bit held;
		do begin
			@(negedge clk);
			held = !calm && ($urandom_range(99) < 11);
			date_ch.valid        <= !held;
			date_ch.day_of_month <= dt.day;
			date_ch.month_number <= dt.month;
			date_ch.full_year    <= dt.year;
		end while (held);
		do @(posedge clk); while (!date_ch.ready);
		sb.note_date(dt.day, dt.month, dt.year);
	endtask

	// Result side: drop ready with a chance of about one in nine, never while calm.
	initial begin
		wday_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			wday_ch.ready <= calm || ($urandom_range(99) >= 11);
		end
	end

	// Check every result beat taken at a rising edge against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && wday_ch.valid && wday_ch.ready) begin
			sb.check_result(wday_ch.weekday, wday_ch.error_code);
		end
	end

	initial begin
		date_t dt;
		int    sel;
		int    mlen;
		bit    leap;

		arst_n               = 1'b0;
		date_ch.valid        = 1'b0;
		date_ch.day_of_month = '0;
		date_ch.month_number = '0;
		date_ch.full_year    = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_DATES[i]) begin
			send_date(DIRECTED_DATES[i]);
		end

		// Mostly real calendar dates with random content; the rest hits leap days,
		// month ends, range edges and fully random fields.
		for (int i = 0; i < RANDOM_DATES; i++) begin
			calm = (i >= 400 && i < 650);
			sel = $urandom_range(99);

			dt.year = 12'($urandom_range(LAST_YEAR, FIRST_YEAR));
			if (sel >= 80 && sel < 85) begin
				dt.year = 12'(Y2K);
			end else if (sel >= 85 && sel < 92) begin
				dt.year = $urandom_range(1) ? 12'($urandom_range(1903, 1897))
					: 12'($urandom_range(2096, 2088));
			end

			dt.month = 4'($urandom_range(12, 1));
			if (sel >= 55 && sel < 62) begin
				dt.month = 4'(FEB);
			end

			leap = (dt.year % 400 == 0) || ((dt.year % 4 == 0) && (dt.year % 100 != 0));
			if (dt.month == FEB) begin
				mlen = leap ? 29 : 28;
			end else if (dt.month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
				mlen = 30;
			end else begin
				mlen = 31;
			end

			dt.day = 6'($urandom_range(mlen, 1));
			if (sel >= 55 && sel < 62) begin
				dt.day = 6'd29;
			end else if (sel >= 62 && sel < 72) begin
				dt.day = 6'($urandom_range(31, 28));
			end

			if (sel >= 92) begin
				dt = date_t'($urandom);
			end
			send_date(dt);
		end
		calm = 1'b0;

		@(negedge clk);
		date_ch.valid <= 1'b0;

		// Drain: wait for every predicted result, then keep watching for strays.
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
